>>> hdl/arm_pkg.sv
// Shared types and constants of the autoranging RMS meter.
// Used by every module of the block; depends on nothing else.
package arm_pkg;

	// Default sizes handed to the top level's parameters.
	localparam int CODE_BITS_DEF   = 10;
	localparam int WINDOW_BITS_DEF = 12;

	// Fixed datapath widths.
	localparam int SUM_BITS   = 42;
	localparam int VALUE_BITS = 16;
	localparam int MV_BITS    = 15;
	localparam int SQ_BITS    = 2 * VALUE_BITS;

	// Configuration port.
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 15;

	localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_LENGTH = 3'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_OFFSET_HIGH   = 3'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_OFFSET_MID    = 3'd2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_THRESH_HIGH   = 3'd3;
	localparam logic [CFG_ADDR_BITS-1:0] REG_THRESH_MID    = 3'd4;

	// Range codes.
	localparam logic [1:0] RANGE_X4 = 2'd0;
	localparam logic [1:0] RANGE_X2 = 2'd1;
	localparam logic [1:0] RANGE_X1 = 2'd2;

	// Scale factor per lane: 2 * 5000 mV * gain, for x4, x2 and x1.
	localparam logic [15:0] GAIN_SCALE [3] = '{16'd40000, 16'd20000, 16'd10000};

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [11:0] window_length;
		logic [12:0] offset_high_mv;
		logic [12:0] offset_mid_mv;
		logic [14:0] threshold_high_mv;
		logic [13:0] threshold_mid_mv;
	} arm_cfg_t;

	// One classified sample travelling from the front to the back.
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] value;
		logic [1:0]                   rng;
		logic                         ac;
		logic                         amp;
	} arm_item_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] reading;
		logic [1:0]                   range_used;
		logic                         unit_amps;
		logic                         is_rms;
	} arm_result_t;

endpackage

>>> hdl/arm_front.sv
// Front part of the meter: converts the three range readings to millivolts
// in three lanes over three pipeline stages and picks the range. Uses arm_pkg.
module arm_front #(
	parameter int CODE_BITS = arm_pkg::CODE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  arm_pkg::arm_cfg_t    cfg,
	input  logic                 push,
	output logic                 full,
	input  logic [CODE_BITS-1:0] code_gain4,
	input  logic [CODE_BITS-1:0] code_gain2,
	input  logic [CODE_BITS-1:0] code_gain1,
	input  logic                 ac_mode,
	input  logic                 amp_mode,
	output logic                 q_push,
	output arm_pkg::arm_item_t   q_item,
	input  logic                 q_full
);
	import arm_pkg::*;

	// Rounded conversion: mv = floor((code * 10000 * g + F) / 2F), F = full scale.
	localparam int NUM_BITS  = CODE_BITS + 16;
	localparam int DIV_BITS  = CODE_BITS + 1;
	localparam int PROD_BITS = NUM_BITS + 16;
	localparam int QD_BITS   = 16 + DIV_BITS;
	localparam logic [NUM_BITS-1:0] FULL_SCALE =
		NUM_BITS'((64'd1 << CODE_BITS) - 64'd1);
	localparam logic [DIV_BITS-1:0] DIVISOR =
		DIV_BITS'((64'd2 << CODE_BITS) - 64'd2);
	localparam logic [63:0] RECIP_FULL =
		(64'd1 << NUM_BITS) / ((64'd2 << CODE_BITS) - 64'd2);
	localparam logic [15:0] RECIP = RECIP_FULL[15:0];

	logic [CODE_BITS-1:0] code [3];
	logic                 advance;
	logic                 take;

	logic                 valid_s1, valid_s2, valid_s3;
	logic                 ac_s1, ac_s2, ac_s3;
	logic                 amp_s1, amp_s2, amp_s3;
	logic [NUM_BITS-1:0]  num_s1 [3];
	logic [NUM_BITS-1:0]  num_s2 [3];
	logic [15:0]          q0_s2 [3];
	logic [MV_BITS-1:0]   mv_s3 [3];

	logic [NUM_BITS-1:0]  scaled [3];
	logic [PROD_BITS-1:0] prod [3];
	logic [QD_BITS-1:0]   qd [3];
	logic [NUM_BITS-1:0]  rest [3];
	logic                 bump [3];

	logic signed [17:0]   cand_hi, cand_mid;

	assign code[0] = code_gain4;
	assign code[1] = code_gain2;
	assign code[2] = code_gain1;

	// The pipeline moves as a whole; it stops only when its last stage
	// holds a sample and the queue has no room.
	assign advance = !valid_s3 || !q_full;
	assign take    = push && advance;
	assign full    = !advance;
	assign q_push  = valid_s3 && !q_full;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			scaled[i] = NUM_BITS'(code[i]) * NUM_BITS'(GAIN_SCALE[i]);
			prod[i]   = PROD_BITS'(num_s1[i]) * PROD_BITS'(RECIP);
			qd[i]     = QD_BITS'(q0_s2[i]) * QD_BITS'(DIVISOR);
			rest[i]   = num_s2[i] - qd[i][NUM_BITS-1:0];
			bump[i]   = rest[i] >= NUM_BITS'(DIVISOR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ac_s1  <= ac_mode;
			amp_s1 <= amp_mode;
			ac_s2  <= ac_s1;
			amp_s2 <= amp_s1;
			ac_s3  <= ac_s2;
			amp_s3 <= amp_s2;
			for (int i = 0; i < 3; i++) begin
				num_s1[i] <= scaled[i] + FULL_SCALE;
				num_s2[i] <= num_s1[i];
				q0_s2[i]  <= prod[i][PROD_BITS-1:NUM_BITS];
				mv_s3[i]  <= MV_BITS'(q0_s2[i] + 16'(bump[i]));
			end
		end
	end

	// Range choice: strict signed comparisons after the offsets are removed.
	always_comb begin
		cand_hi  = $signed({3'b0, mv_s3[0]}) - $signed({5'b0, cfg.offset_high_mv});
		cand_mid = $signed({3'b0, mv_s3[1]}) - $signed({5'b0, cfg.offset_mid_mv});
		q_item.ac  = ac_s3;
		q_item.amp = amp_s3;
		if (cand_hi > $signed({3'b0, cfg.threshold_high_mv})) begin
			q_item.value = cand_hi[VALUE_BITS-1:0];
			q_item.rng   = RANGE_X4;
		end else if (cand_mid > $signed({4'b0, cfg.threshold_mid_mv})) begin
			q_item.value = cand_mid[VALUE_BITS-1:0];
			q_item.rng   = RANGE_X2;
		end else begin
			q_item.value = VALUE_BITS'(mv_s3[2]);
			q_item.rng   = RANGE_X1;
		end
	end

endmodule

>>> hdl/arm_fifo.sv
// Short queue of classified samples between the front and the back.
// Uses the item type from arm_pkg.
module arm_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  arm_pkg::arm_item_t wr_item,
	output logic               q_full,
	input  logic               rd_en,
	output arm_pkg::arm_item_t rd_item,
	output logic               q_empty
);
	import arm_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(QUEUE_DEPTH - 1);

	arm_item_t           slot_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign q_full  = count_q == CNT_BITS'(QUEUE_DEPTH);
	assign q_empty = count_q == '0;
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_BITS'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_BITS'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

>>> hdl/arm_back.sv
// Back part of the meter: window accumulation, restoring divider, bitwise
// square root and the output register. Uses arm_pkg.
module arm_back #(
	parameter int WINDOW_BITS = arm_pkg::WINDOW_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  arm_pkg::arm_cfg_t    cfg,
	input  logic                 q_empty,
	input  arm_pkg::arm_item_t   q_item,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output arm_pkg::arm_result_t result
);
	import arm_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SQUARE = 6'b000010,
		ST_ACC    = 6'b000100,
		ST_DIV    = 6'b001000,
		ST_SQRT   = 6'b010000,
		ST_EMIT   = 6'b100000
	} back_state_t;

	localparam int STEP_BITS = $clog2(SUM_BITS);

	back_state_t                  state_q;
	logic                         prev_ac_q;
	logic [SUM_BITS-1:0]          sum_q;
	logic [WINDOW_BITS-1:0]       cnt_q;
	logic                         out_v_q;

	arm_item_t                    item_q;
	logic signed [VALUE_BITS-1:0] res_value_q;
	logic [SQ_BITS-1:0]           sq_q;
	logic [SUM_BITS-1:0]          quo_q;
	logic [WINDOW_BITS-1:0]       rem_q;
	logic [WINDOW_BITS-1:0]       divisor_q;
	logic [STEP_BITS-1:0]         step_q;
	logic [SUM_BITS-1:0]          root_q;
	logic [SUM_BITS-1:0]          bit_q;
	arm_result_t                  out_q;

	logic [WINDOW_BITS-1:0]       win_w, win_eff;
	logic [VALUE_BITS-1:0]        mag;
	logic [SUM_BITS-1:0]          sum_next;
	logic [WINDOW_BITS-1:0]       cnt_next;
	logic                         window_done;
	logic [WINDOW_BITS:0]         rem_sh, rem_diff;
	logic                         div_ge;
	logic [SUM_BITS-1:0]          quo_next;
	logic [SUM_BITS-1:0]          trial;
	logic                         sq_ge;
	logic [SUM_BITS-1:0]          root_next;
	logic                         emit_ok;
	logic                         load_out;

	// A zero window counts as a window of one.
	assign win_w   = WINDOW_BITS'(cfg.window_length);
	assign win_eff = (win_w == '0) ? WINDOW_BITS'(1) : win_w;

	assign mag         = item_q.value[VALUE_BITS-1] ? (~item_q.value + 16'd1) : item_q.value;
	assign sum_next    = sum_q + SUM_BITS'(sq_q);
	assign cnt_next    = cnt_q + WINDOW_BITS'(1);
	assign window_done = (cnt_next == '0) || (cnt_next >= win_eff);

	assign rem_sh   = {rem_q, quo_q[SUM_BITS-1]};
	assign rem_diff = rem_sh - {1'b0, divisor_q};
	assign div_ge   = rem_sh >= {1'b0, divisor_q};
	assign quo_next = {quo_q[SUM_BITS-2:0], div_ge};

	// The radicand lives in quo_q once the division is done.
	assign trial     = root_q + bit_q;
	assign sq_ge     = quo_q >= trial;
	assign root_next = sq_ge ? ((root_q >> 1) + bit_q) : (root_q >> 1);

	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign emit_ok  = !out_v_q || pop;
	assign load_out = (state_q == ST_EMIT) && emit_ok;

	assign empty  = !out_v_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			prev_ac_q <= 1'b0;
			sum_q     <= '0;
			cnt_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						prev_ac_q <= q_item.ac;
						if (q_item.ac != prev_ac_q) begin
							sum_q <= '0;
							cnt_q <= '0;
						end
						state_q <= q_item.ac ? ST_SQUARE : ST_EMIT;
					end
				end
				ST_SQUARE: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (window_done) begin
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						sum_q   <= sum_next;
						cnt_q   <= cnt_next;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_BITS'(SUM_BITS - 1)) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (bit_q[0]) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.reading    <= res_value_q;
			out_q.range_used <= item_q.rng;
			out_q.unit_amps  <= item_q.amp;
			out_q.is_rms     <= item_q.ac;
		end
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					item_q      <= q_item;
					res_value_q <= q_item.value;
				end
			end
			ST_SQUARE: begin
				sq_q <= SQ_BITS'(mag) * SQ_BITS'(mag);
			end
			ST_ACC: begin
				quo_q     <= sum_next;
				rem_q     <= '0;
				divisor_q <= (cnt_next == '0) ? WINDOW_BITS'(1) : cnt_next;
				step_q    <= '0;
			end
			ST_DIV: begin
				rem_q  <= div_ge ? rem_diff[WINDOW_BITS-1:0] : rem_sh[WINDOW_BITS-1:0];
				quo_q  <= quo_next;
				step_q <= step_q + STEP_BITS'(1);
				root_q <= '0;
				bit_q  <= SUM_BITS'(1) << (SUM_BITS - 2);
			end
			ST_SQRT: begin
				if (sq_ge) begin
					quo_q <= quo_q - trial;
				end
				root_q <= root_next;
				bit_q  <= bit_q >> 2;
				if (bit_q[0]) begin
					res_value_q <= root_next[VALUE_BITS-1:0];
				end
			end
			ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hdl/autorange_rms_meter_core.sv
// Top level of the autoranging true-RMS meter: configuration registers,
// front, queue and back. Depends on arm_pkg, arm_front, arm_fifo, arm_back.

// Each input beat carries three converter readings of one signal (x4, x2, x1
// range) and the AC and current switches. The front turns all three readings
// into millivolts in parallel over three pipeline stages and picks the range;
// a sample moves on from the last stage once the queue has room and waits in a
// two-entry queue. The back handles one sample at a time. A DC sample goes
// from the idle state to the emit state, which loads its result into the
// output register; an AC sample inside the window passes through the idle,
// square and accumulate states and gives nothing. The AC sample that closes
// a window also passes through the restoring divider that forms the mean (one
// quotient bit per cycle) and the square root (one root bit per cycle) before
// the emit state loads the output register. A result that is not popped holds
// the back in its emit state. A change between AC and DC clears the window.
// Results wait in an output register, and the queue lets the front keep
// taking samples while the back computes or the result side stalls. The user
// must write configuration only while the block is idle; the block itself does
// not enforce this. The port is always ready and writes to unknown indexes are
// dropped.
module autorange_rms_meter_core #(
	parameter int CODE_BITS   = arm_pkg::CODE_BITS_DEF,
	parameter int WINDOW_BITS = arm_pkg::WINDOW_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [CODE_BITS-1:0]                code_gain4,
	input  logic [CODE_BITS-1:0]                code_gain2,
	input  logic [CODE_BITS-1:0]                code_gain1,
	input  logic                                ac_mode,
	input  logic                                amp_mode,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [arm_pkg::VALUE_BITS-1:0] reading,
	output logic [1:0]                          range_used,
	output logic                                unit_amps,
	output logic                                is_rms,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [arm_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
	input  logic [arm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
	import arm_pkg::*;

	arm_cfg_t    cfg_q;
	logic        q_push, q_full, q_pop, q_empty;
	arm_item_t   front_item, back_item;
	arm_result_t result;

	// Most registers are narrower than the data bus; their upper bits are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_length     <= 12'd3000;
			cfg_q.offset_high_mv    <= 13'd2280;
			cfg_q.offset_mid_mv     <= 13'd520;
			cfg_q.threshold_high_mv <= 15'd10000;
			cfg_q.threshold_mid_mv  <= 14'd5000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_WINDOW_LENGTH: cfg_q.window_length     <= cfg_wdata[11:0];
				REG_OFFSET_HIGH:   cfg_q.offset_high_mv    <= cfg_wdata[12:0];
				REG_OFFSET_MID:    cfg_q.offset_mid_mv     <= cfg_wdata[12:0];
				REG_THRESH_HIGH:   cfg_q.threshold_high_mv <= cfg_wdata[14:0];
				REG_THRESH_MID:    cfg_q.threshold_mid_mv  <= cfg_wdata[13:0];
				default: begin
				end
			endcase
		end
	end

	arm_front #(
		.CODE_BITS(CODE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.code_gain4(code_gain4),
		.code_gain2(code_gain2),
		.code_gain1(code_gain1),
		.ac_mode   (ac_mode),
		.amp_mode  (amp_mode),
		.q_push    (q_push),
		.q_item    (front_item),
		.q_full    (q_full)
	);

	arm_fifo u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_item(front_item),
		.q_full (q_full),
		.rd_en  (q_pop),
		.rd_item(back_item),
		.q_empty(q_empty)
	);

	arm_back #(
		.WINDOW_BITS(WINDOW_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_empty(q_empty),
		.q_item (back_item),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	assign reading    = result.reading;
	assign range_used = result.range_used;
	assign unit_amps  = result.unit_amps;
	assign is_rms     = result.is_rms;

	// The back only takes a sample that the queue really holds.
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back took a sample from an empty queue");

	// The front only hands a sample over when the queue has room.
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("front wrote into a full queue");

	// A root-mean-square result can never be negative.
	a_rms_nonnegative: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_rms) |-> !reading[VALUE_BITS-1])
		else $error("negative RMS reading");

endmodule

>>> verif/autorange_rms_meter_core_tb.sv
// Self-checking testbench for autorange_rms_meter_core: a directed table, then random phases.
// It predicts every reading and checks the result queue against it.
// Depends on arm_pkg and autorange_rms_meter_core only.
module autorange_rms_meter_core_tb;
	import arm_pkg::*;

	localparam int CODE_W        = CODE_BITS_DEF;
	localparam int WIN_W         = WINDOW_BITS_DEF;
	localparam longint FULL      = (longint'(1) << CODE_W) - 1;
	localparam logic [CODE_W-1:0] CODE_MAX = '1;
	// A window-closing AC sample passes through the divider and the square root in the back. A few more samples may
	// still sit in the front and the queue, so this margin covers both.
	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_ITEMS  = 1600;
	localparam int CALM_ITEMS    = 200;
	localparam int CYCLE_LIMIT   = 800000;
	localparam int REPORT_MAX    = 10;

	// Indexes that map to no register. The block must drop writes to them.
	localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [CODE_W-1:0] code4;
		logic [CODE_W-1:0] code2;
		logic [CODE_W-1:0] code1;
		logic              ac;
		logic              amp;
	} sample_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	// One line of the directed table. A row is either a sample or a register write.
	// Sample rows with 'known' set carry a reading that is typed in by hand.
	typedef struct {
		row_kind_t                 kind;
		sample_t                   s;
		bit                        known;
		arm_result_t               want;
		logic [CFG_ADDR_BITS-1:0]  addr;
		logic [CFG_DATA_BITS-1:0]  data;
	} row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [CODE_W-1:0] code_gain4 = '0;
	logic [CODE_W-1:0] code_gain2 = '0;
	logic [CODE_W-1:0] code_gain1 = '0;
	logic ac_mode = 1'b0;
	logic amp_mode = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [VALUE_BITS-1:0] reading;
	logic [1:0] range_used;
	logic unit_amps;
	logic is_rms;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	autorange_rms_meter_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.code_gain4 (code_gain4),
		.code_gain2 (code_gain2),
		.code_gain1 (code_gain1),
		.ac_mode    (ac_mode),
		.amp_mode   (amp_mode),
		.empty      (empty),
		.pop        (pop),
		.reading    (reading),
		.range_used (range_used),
		.unit_amps  (unit_amps),
		.is_rms     (is_rms),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata)
	);

	// Mirror of the meter: its register file and its window accumulator.
	arm_cfg_t          meter_cfg;
	logic [SUM_BITS-1:0] sum_sq;
	logic [WIN_W-1:0]  samples_in_window;
	logic              last_ac;

	arm_result_t pending_readings[$];
	row_t        directed_rows[$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          random_sent = 0;
	bit          calm = 1'b0;
	bit          cfg_open = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Millivolts of one converter code at a given gain, rounded with ties upward.
	function automatic int lane_mv(logic [CODE_W-1:0] code, int gain);
		longint num;
		num = longint'(code) * 10000 * gain + FULL;
		return int'(num / (2 * FULL));
	endfunction

	// Picks the range for one sample, updates the window and returns 1 when the
	// sample gives a reading. A DC sample always does; an AC sample only when it
	// closes the window, and then the reading is the truncated root of the mean square.
	function automatic bit meter_predict(sample_t s, output arm_result_t r);
		int v;
		int mag;
		logic [1:0] rng;
		logic [WIN_W-1:0] win;
		longint unsigned mean;
		longint unsigned cand;
		longint unsigned root;
		v = lane_mv(s.code4, 4) - int'(meter_cfg.offset_high_mv);
		rng = RANGE_X4;
		if (!(v > int'(meter_cfg.threshold_high_mv))) begin
			v = lane_mv(s.code2, 2) - int'(meter_cfg.offset_mid_mv);
			rng = RANGE_X2;
			if (!(v > int'(meter_cfg.threshold_mid_mv))) begin
				v = lane_mv(s.code1, 1);
				rng = RANGE_X1;
			end
		end
		// Switching between AC and DC throws away a partly filled window.
		if (s.ac != last_ac) begin
			sum_sq = '0;
			samples_in_window = '0;
		end
		last_ac = s.ac;
		r.range_used = rng;
		r.unit_amps = s.amp;
		r.is_rms = s.ac;
		if (!s.ac) begin
			r.reading = v[VALUE_BITS-1:0];
			return 1'b1;
		end
		mag = (v < 0) ? -v : v;
		sum_sq = SUM_BITS'(sum_sq + longint'(mag) * longint'(mag));
		samples_in_window = samples_in_window + WIN_W'(1);
		// A window of zero acts as a window of one. A window lowered below the count
		// closes at the next AC sample over what has been summed so far.
		win = meter_cfg.window_length;
		if (win == '0)
			win = 1;
		if (samples_in_window != '0 && samples_in_window < win)
			return 1'b0;
		if (samples_in_window == '0)
			samples_in_window = 1;
		mean = 64'(sum_sq) / 64'(samples_in_window);
		root = 0;
		for (int b = 21; b >= 0; b--) begin
			cand = root | (longint'(1) << b);
			if (cand * cand <= mean)
				root = cand;
		end
		r.reading = root[VALUE_BITS-1:0];
		sum_sq = '0;
		samples_in_window = '0;
		return 1'b1;
	endfunction

	function automatic void mirror_write(logic [CFG_ADDR_BITS-1:0] addr,
			logic [CFG_DATA_BITS-1:0] data);
		case (addr)
			REG_WINDOW_LENGTH: meter_cfg.window_length = data[11:0];
			REG_OFFSET_HIGH:   meter_cfg.offset_high_mv = data[12:0];
			REG_OFFSET_MID:    meter_cfg.offset_mid_mv = data[12:0];
			REG_THRESH_HIGH:   meter_cfg.threshold_high_mv = data[14:0];
			REG_THRESH_MID:    meter_cfg.threshold_mid_mv = data[13:0];
			default: begin
			end
		endcase
	endfunction

	function automatic void note_mismatch(string what, arm_result_t want, arm_result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("MISMATCH %s: expected reading=%0d range=%0d amps=%0b rms=%0b, got reading=%0d range=%0d amps=%0b rms=%0b",
				what, want.reading, want.range_used, want.unit_amps, want.is_rms,
				got.reading, got.range_used, got.unit_amps, got.is_rms);
	endfunction

	function automatic logic [CODE_W-1:0] random_code();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return CODE_MAX;
			default: return CODE_W'($urandom_range(0, int'(FULL)));
		endcase
	endfunction

	// Table builders for the directed part.
	task automatic add_sample(int c4, int c2, int c1, bit ac, bit amp);
		row_t row;
		row.kind = ROW_SAMPLE;
		row.s = '{code4: CODE_W'(c4), code2: CODE_W'(c2), code1: CODE_W'(c1), ac: ac, amp: amp};
		row.known = 1'b0;
		row.want = '0;
		row.addr = '0;
		row.data = '0;
		directed_rows.push_back(row);
	endtask

	task automatic add_known(int c4, int c2, int c1, bit ac, bit amp, int value,
			logic [1:0] rng);
		add_sample(c4, c2, c1, ac, amp);
		directed_rows[$].known = 1'b1;
		directed_rows[$].want = '{reading: VALUE_BITS'(value), range_used: rng,
			unit_amps: amp, is_rms: ac};
	endtask

	task automatic add_write(logic [CFG_ADDR_BITS-1:0] addr, int data);
		row_t row;
		row.kind = ROW_WRITE;
		row.s = '0;
		row.known = 1'b0;
		row.want = '0;
		row.addr = addr;
		row.data = CFG_DATA_BITS'(data);
		directed_rows.push_back(row);
	endtask

	// Offers one sample and holds it until the block takes it. Push is left high so that
	// back-to-back samples need no second assignment within one time step.
	task automatic send_sample(sample_t s, bit known, arm_result_t known_res);
		arm_result_t res;
		push <= 1'b1;
		code_gain4 <= s.code4;
		code_gain2 <= s.code2;
		code_gain1 <= s.code1;
		ac_mode <= s.ac;
		amp_mode <= s.amp;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (meter_predict(s, res))
			pending_readings.push_back(known ? known_res : res);
	endtask

	// The sender stops until every predicted reading has been popped, then lets the
	// block finish any AC sample that gives no reading but is still in flight.
	task automatic settle_block();
		push <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register. Valid stays high for a following write; cfg_release drops it.
	task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mirror_write(addr, data);
	endtask

	task automatic cfg_release();
		cfg_valid <= 1'b0;
	endtask

	// Result side: pop stalls come in bursts of random length, except in the calm tail.
	// Each popped beat is held against the oldest predicted reading.
	int stall_left = 0;
	always @(posedge clk) begin
		arm_result_t got;
		arm_result_t want;
		if (arst_n && pop && !empty) begin
			got = '{reading: reading, range_used: range_used, unit_amps: unit_amps,
				is_rms: is_rms};
			if (pending_readings.size() == 0) begin
				note_mismatch("unexpected result", '0, got);
			end else begin
				want = pending_readings.pop_front();
				if (got.reading !== want.reading || got.range_used !== want.range_used ||
						got.unit_amps !== want.unit_amps || got.is_rms !== want.is_rms)
					note_mismatch("result fields", want, got);
			end
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 11);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int phase_idx;
		int phase_len;
		int sent_in_phase;
		int run_len;
		int win_eff;
		int pick;
		bit run_ac;
		sample_t s;
		logic [CFG_DATA_BITS-1:0] win_val;

		// Reset values of the register file and the window.
		meter_cfg = '{window_length: 12'd3000, offset_high_mv: 13'd2280,
			offset_mid_mv: 13'd520, threshold_high_mv: 15'd10000,
			threshold_mid_mv: 14'd5000};
		sum_sq = '0;
		samples_in_window = '0;
		last_ac = 1'b0;

		// Directed table. Readings typed in by hand use the reset offsets and thresholds:
		// a full-scale x4 code is 20000 mV, less 2280; a full-scale x2 code is 10000 mV,
		// less 520; a full-scale x1 code is 5000 mV.
		add_known(0, 0, 0, 0, 0, 0, RANGE_X1);
		add_known(1023, 0, 0, 0, 0, 17720, RANGE_X4);
		add_known(0, 1023, 0, 0, 0, 9480, RANGE_X2);
		add_known(0, 0, 1023, 0, 1, 5000, RANGE_X1);
		add_known(1023, 1023, 1023, 0, 1, 17720, RANGE_X4);
		add_sample(628, 700, 300, 0, 0);
		add_sample(629, 400, 0, 0, 1);
		// A window of one gives the sample's own magnitude as its RMS.
		add_write(REG_WINDOW_LENGTH, 1);
		add_known(1023, 1023, 1023, 1, 0, 17720, RANGE_X4);
		// A window of zero must act like a window of one.
		add_write(REG_WINDOW_LENGTH, 0);
		add_known(0, 0, 1023, 1, 1, 5000, RANGE_X1);
		add_write(REG_WINDOW_LENGTH, 3);
		add_sample(900, 500, 200, 1, 0);
		add_sample(100, 800, 600, 1, 1);
		add_sample(10, 20, 1000, 1, 0);
		// Two AC samples, then a DC sample that clears the partial window.
		add_sample(700, 100, 100, 1, 0);
		add_sample(300, 1023, 50, 1, 0);
		add_sample(300, 300, 300, 0, 0);
		// Window lowered while samples are waiting: the next AC sample closes it.
		add_sample(1023, 0, 0, 1, 0);
		add_sample(0, 0, 512, 1, 1);
		add_write(REG_WINDOW_LENGTH, 1);
		add_sample(0, 1023, 0, 1, 0);
		// All offsets and thresholds at zero.
		add_write(REG_OFFSET_HIGH, 0);
		add_write(REG_OFFSET_MID, 0);
		add_write(REG_THRESH_HIGH, 0);
		add_write(REG_THRESH_MID, 0);
		add_known(0, 0, 0, 0, 0, 0, RANGE_X1);
		add_sample(1, 0, 0, 0, 0);
		add_sample(0, 1, 0, 0, 1);
		// Offsets at 5000 and thresholds at full scale: neither gain range can pass its threshold.
		add_write(REG_OFFSET_HIGH, 5000);
		add_write(REG_OFFSET_MID, 5000);
		add_write(REG_THRESH_HIGH, 20000);
		add_write(REG_THRESH_MID, 10000);
		add_write(REG_SPARE_HI, 16'h7fff);
		add_known(1023, 1023, 1023, 0, 0, 5000, RANGE_X1);
		// The threshold comparisons are strict: 20000 mV does not pass 20000.
		add_write(REG_OFFSET_HIGH, 0);
		add_sample(1023, 1023, 0, 0, 0);
		add_write(REG_THRESH_HIGH, 19999);
		add_write(REG_SPARE_LO, 0);
		add_sample(1023, 0, 0, 0, 1);
		add_sample(1023, 0, 0, 1, 1);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				if (!cfg_open)
					settle_block();
				write_reg(directed_rows[i].addr, directed_rows[i].data);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open)
					cfg_release();
				cfg_open = 1'b0;
				send_sample(directed_rows[i].s, directed_rows[i].known, directed_rows[i].want);
			end
		end

		// Random phases. Each one starts from an idle block with a fresh register set;
		// the window state carries over, so a shorter window can land on a partial one.
		phase_idx = 0;
		while (random_sent < RANDOM_ITEMS) begin
			settle_block();
			pick = $urandom_range(0, 9);
			case (pick)
				0: win_val = 0;
				1: win_val = 1;
				2: win_val = 4095;
				3, 4, 5, 6: win_val = CFG_DATA_BITS'($urandom_range(2, 8));
				7, 8: win_val = CFG_DATA_BITS'($urandom_range(9, 40));
				default: win_val = CFG_DATA_BITS'($urandom_range(41, 300));
			endcase
			if (phase_idx == 1)
				win_val = 4095;
			write_reg(REG_WINDOW_LENGTH, win_val);
			pick = $urandom_range(0, 5);
			write_reg(REG_OFFSET_HIGH, CFG_DATA_BITS'((pick == 0) ? 0 : (pick == 1) ? 5000 :
				$urandom_range(0, 5000)));
			pick = $urandom_range(0, 5);
			write_reg(REG_OFFSET_MID, CFG_DATA_BITS'((pick == 0) ? 0 : (pick == 1) ? 5000 :
				$urandom_range(0, 5000)));
			pick = $urandom_range(0, 5);
			write_reg(REG_THRESH_HIGH, CFG_DATA_BITS'((pick == 0) ? 0 : (pick == 1) ? 20000 :
				$urandom_range(0, 20000)));
			pick = $urandom_range(0, 5);
			write_reg(REG_THRESH_MID, CFG_DATA_BITS'((pick == 0) ? 0 : (pick == 1) ? 10000 :
				$urandom_range(0, 10000)));
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_ADDR_BITS'($urandom_range(5, 7)),
					CFG_DATA_BITS'($urandom_range(0, 32767)));
			cfg_release();

			win_eff = (meter_cfg.window_length == 0) ? 1 : int'(meter_cfg.window_length);
			phase_len = $urandom_range(60, 120);
			sent_in_phase = 0;
			while (sent_in_phase < phase_len && random_sent < RANDOM_ITEMS) begin
				// Mostly AC runs around the window length; DC runs and cut-short
				// windows make up the rest.
				run_ac = ($urandom_range(0, 3) != 0);
				if (run_ac) begin
					run_len = $urandom_range(1, 2 * win_eff);
					if (run_len > 60)
						run_len = 60;
				end else begin
					run_len = $urandom_range(1, 6);
				end
				for (int k = 0; k < run_len && random_sent < RANDOM_ITEMS; k++) begin
					if (!calm && $urandom_range(0, 199) == 0)
						settle_block();
					else if (!calm && $urandom_range(0, 5) == 0) begin
						push <= 1'b0;
						repeat ($urandom_range(1, 12)) @(posedge clk);
					end
					s.code4 = random_code();
					s.code2 = random_code();
					s.code1 = random_code();
					s.ac = run_ac;
					s.amp = $urandom_range(0, 1);
					send_sample(s, 1'b0, '0);
					random_sent++;
					sent_in_phase++;
					calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
				end
			end
			phase_idx++;
		end

		// Drain and give the block time to show any stray beat.
		push <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_readings.size() != 0)
			note_mismatch("reading never arrived", pending_readings[0], '0);

		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
